@@ rtl/kpsd_pkg.sv @@
// Shared types, constants and the hex font for the keypad scanner / seven-segment display.
// Used by kpsd_key_decode and keypad_to_scrolling_seven_segment_top.
// No dependencies.
package kpsd_pkg;

    // display geometry
    localparam int DIGITS       = 8;
    localparam int POS_W        = $clog2(DIGITS);
    localparam int SUM_W        = POS_W + 1;
    localparam int SEG_W        = 7;
    localparam int DIGIT_SEL_W  = 3;

    // keypad geometry
    localparam int ROWS         = 4;
    localparam int COLS         = 4;
    localparam int KEY_W        = ROWS * COLS;
    localparam int KEY_IDX_W    = $clog2(KEY_W);

    // stream widths
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;

    // decoded key of one tick
    typedef struct packed {
        logic                  hit;      // some row has exactly one key down
        logic [KEY_IDX_W-1:0]  index;    // row*4+col
        logic [SEG_W-1:0]      pattern;  // hex glyph of the key
    } key_code_t;

    // hex font, segment a in bit 0
    function automatic logic [SEG_W-1:0] hex_font(input logic [KEY_IDX_W-1:0] idx);
        logic [SEG_W-1:0] seg;
        case (idx)
            4'h0:    seg = 7'h3f;
            4'h1:    seg = 7'h06;
            4'h2:    seg = 7'h5b;
            4'h3:    seg = 7'h4f;
            4'h4:    seg = 7'h66;
            4'h5:    seg = 7'h6d;
            4'h6:    seg = 7'h7d;
            4'h7:    seg = 7'h07;
            4'h8:    seg = 7'h7f;
            4'h9:    seg = 7'h6f;
            4'ha:    seg = 7'h77;
            4'hb:    seg = 7'h7c;
            4'hc:    seg = 7'h58;
            4'hd:    seg = 7'h5e;
            4'he:    seg = 7'h79;
            default: seg = 7'h71;
        endcase
        return seg;
    endfunction

endpackage

@@ rtl/keypad_to_scrolling_seven_segment_top.sv @@
// Keypad scanner feeding a scrolling eight-digit seven-segment display, top level.
// Depends on kpsd_pkg and kpsd_key_decode.
//
// One transfer on s_ is one refresh tick carrying the key matrix; every tick yields
// exactly one transfer on m_ with the glyph and index of the digit to drive. The block
// takes one tick per clock while m_ is not stalled, and the result appears on m_ the
// cycle after acceptance, set by the registered read of the digit ring memory, which
// doubles as the output register. A new key (one whose code differs from the previous
// tick) is written into the ring in the same cycle; a read of that same entry is
// forwarded. Per-entry valid bits make never-written digits read blank right after
// reset, so no clearing pass is needed.
module keypad_to_scrolling_seven_segment_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kpsd_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] keys_pressed
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kpsd_pkg::M_TDATA_W-1:0]  m_tdata    // [6:0] segments, [9:7] digit_select
);

    kpsd_pkg::key_code_t code;

    logic [kpsd_pkg::POS_W-1:0] write_pos_reg, write_pos_next;
    logic [kpsd_pkg::POS_W-1:0] scan_pos_reg,  scan_pos_next;
    logic                       prev_hit_reg;
    logic [kpsd_pkg::SEG_W-1:0] prev_pattern_reg;
    logic [kpsd_pkg::DIGITS-1:0] entry_valid_reg;
    logic                       m_valid_reg, m_valid_next;

    logic [kpsd_pkg::SEG_W-1:0] ring_mem [kpsd_pkg::DIGITS];
    logic [kpsd_pkg::SEG_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;
    logic                       fwd_reg;
    logic [kpsd_pkg::SEG_W-1:0] fwd_data_reg;
    logic [kpsd_pkg::POS_W-1:0] sel_reg;

    logic                       s_fire;
    logic                       wr_en;
    logic                       fwd_next;
    logic [kpsd_pkg::SUM_W-1:0] idx_sum;
    logic [kpsd_pkg::POS_W-1:0] rd_idx;
    logic [kpsd_pkg::SEG_W-1:0] segments;

    kpsd_key_decode u_decode (
        .keys_pressed (s_tdata[kpsd_pkg::KEY_W-1:0]),
        .code         (code)
    );

    // handshake: the output register is the only buffer
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // write on a fresh key
    assign wr_en = s_fire && code.hit && (!prev_hit_reg || (code.pattern != prev_pattern_reg));

    // position updates, wrapping at DIGITS
    always_comb begin
        write_pos_next = write_pos_reg;
        if (wr_en) begin
            write_pos_next = (write_pos_reg == kpsd_pkg::POS_W'(kpsd_pkg::DIGITS - 1))
                           ? '0 : write_pos_reg + 1'b1;
        end
        scan_pos_next = (scan_pos_reg == kpsd_pkg::POS_W'(kpsd_pkg::DIGITS - 1))
                      ? '0 : scan_pos_reg + 1'b1;
    end

    // read index uses the advanced write position
    always_comb begin
        idx_sum = {1'b0, scan_pos_reg} + {1'b0, write_pos_next};
        if (idx_sum >= kpsd_pkg::SUM_W'(kpsd_pkg::DIGITS)) begin
            idx_sum = idx_sum - kpsd_pkg::SUM_W'(kpsd_pkg::DIGITS);
        end
        rd_idx = idx_sum[kpsd_pkg::POS_W-1:0];
    end

    assign fwd_next = wr_en && (rd_idx == write_pos_reg);

    // control state
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_pos_reg   <= '0;
            scan_pos_reg    <= '0;
            prev_hit_reg    <= 1'b0;
            entry_valid_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                write_pos_reg <= write_pos_next;
                scan_pos_reg  <= scan_pos_next;
                prev_hit_reg  <= code.hit;
            end
            if (wr_en) begin
                entry_valid_reg[write_pos_reg] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            prev_pattern_reg <= code.pattern;
            rd_valid_reg     <= entry_valid_reg[rd_idx];
            fwd_reg          <= fwd_next;
            fwd_data_reg     <= code.pattern;
            sel_reg          <= scan_pos_reg;
        end
    end

    // digit ring: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[write_pos_reg] <= code.pattern;
        end
        if (s_fire) begin
            rd_data_reg <= ring_mem[rd_idx];
        end
    end

    // result select: forwarded write, stored digit, or blank
    always_comb begin
        if (fwd_reg) begin
            segments = fwd_data_reg;
        end else if (rd_valid_reg) begin
            segments = rd_data_reg;
        end else begin
            segments = '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(kpsd_pkg::M_TDATA_W - kpsd_pkg::SEG_W - kpsd_pkg::DIGIT_SEL_W){1'b0}},
                       kpsd_pkg::DIGIT_SEL_W'(sel_reg), segments};

    // a waiting result blocks new transfers
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while result is stalled");

    // forwarding only on a write
    a_fwd_needs_write: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_next |-> wr_en)
        else $error("forward without ring write");

    // the write position moves only with a write
    a_wp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !wr_en |=> $stable(write_pos_reg))
        else $error("write position moved without a write");

    // a written entry is marked valid
    a_entry_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> entry_valid_reg[$past(write_pos_reg)])
        else $error("written entry not marked valid");

endmodule

@@ rtl/kpsd_key_decode.sv @@
// Priority decode of the 4x4 key matrix into a key code and its hex glyph.
// Depends on kpsd_pkg.
module kpsd_key_decode (
    input  logic [kpsd_pkg::KEY_W-1:0] keys_pressed,
    output kpsd_pkg::key_code_t        code
);

    // first row with exactly one column down wins; ambiguous rows are skipped
    always_comb begin
        logic [kpsd_pkg::COLS-1:0] cols;
        logic [1:0]                col;
        logic                      one;
        code = '0;
        for (int r = kpsd_pkg::ROWS - 1; r >= 0; r--) begin
            cols = keys_pressed[r*kpsd_pkg::COLS +: kpsd_pkg::COLS];
            one  = 1'b1;
            col  = 2'd0;
            case (cols)
                4'b0001: col = 2'd0;
                4'b0010: col = 2'd1;
                4'b0100: col = 2'd2;
                4'b1000: col = 2'd3;
                default: one = 1'b0;
            endcase
            if (one) begin
                code.hit     = 1'b1;
                code.index   = {2'(r), col};
                code.pattern = kpsd_pkg::hex_font({2'(r), col});
            end
        end
    end

endmodule

@@ tb/tb.sv @@
// Self-checking bench for keypad_to_scrolling_seven_segment_top: key-matrix ticks in,
// checked digit glyphs out. Depends on kpsd_pkg and the RTL top level only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int        N_RANDOM     = 1850;
    localparam int        QUIET_TAIL   = 120;      // last transfers run without idling
    localparam int        LIMIT_CYCLES = 200000;
    localparam int        DRAIN_CYCLES = 10;
    localparam logic [7:0] NO_KEY      = 8'hff;

    // m_tdata layout
    localparam int SEG_LO = 0;
    localparam int SEL_LO = kpsd_pkg::SEG_W;

    // hex glyphs, segment a in bit 0
    localparam logic [kpsd_pkg::SEG_W-1:0] GLYPH [16] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07,
        7'h7f, 7'h6f, 7'h77, 7'h7c, 7'h58, 7'h5e, 7'h79, 7'h71
    };

    typedef struct packed {
        logic [kpsd_pkg::SEG_W-1:0]       segments;
        logic [kpsd_pkg::DIGIT_SEL_W-1:0] digit_select;
    } glyph_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [kpsd_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [kpsd_pkg::M_TDATA_W-1:0]   m_tdata;

    // stimulus and expectations
    logic [kpsd_pkg::KEY_W-1:0]   pending_keys [$];
    glyph_t                       expected_glyphs [$];

    // display model state
    logic [kpsd_pkg::SEG_W-1:0]   ring_glyph [kpsd_pkg::DIGITS];
    logic [kpsd_pkg::POS_W-1:0]   write_ptr;
    logic [kpsd_pkg::POS_W-1:0]   scan_ptr;
    logic [7:0]                   last_code;

    int unsigned cycle_count  = 0;
    int unsigned mismatches   = 0;
    int unsigned ticks_sent   = 0;
    int unsigned new_keys     = 0;
    int unsigned glyphs_seen  = 0;
    int unsigned src_gap      = 0;
    int unsigned snk_stall    = 0;
    int unsigned src_rate     = 0;
    int unsigned snk_rate     = 0;

    keypad_to_scrolling_seven_segment_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] keys_pressed
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [6:0] segments, [9:7] digit_select
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [kpsd_pkg::POS_W-1:0] next_pos(
        input logic [kpsd_pkg::POS_W-1:0] p);
        return (p == kpsd_pkg::POS_W'(kpsd_pkg::DIGITS - 1)) ? '0 : p + 1'b1;
    endfunction

    // scan rows in order; first row with exactly one column down wins
    function automatic logic [7:0] key_glyph(input logic [kpsd_pkg::KEY_W-1:0] keys);
        logic [3:0] cols;
        for (int r = 0; r < kpsd_pkg::ROWS; r++) begin
            cols = keys[r*kpsd_pkg::COLS +: kpsd_pkg::COLS];
            if ($countones(cols) == 1) begin
                for (int c = 0; c < kpsd_pkg::COLS; c++)
                    if (cols[c])
                        return {1'b0, GLYPH[r*kpsd_pkg::COLS + c]};
            end
        end
        return NO_KEY;
    endfunction

    // row nibble that never qualifies: blank or two or more keys
    function automatic logic [3:0] dead_row();
        logic [3:0] n;
        n = 4'($urandom_range(0, 15));
        while ($countones(n) == 1)
            n = 4'($urandom_range(0, 15));
        return n;
    endfunction

    // matrix that decodes to one key, with random clutter around it
    function automatic logic [kpsd_pkg::KEY_W-1:0] press_word(input int key);
        logic [kpsd_pkg::KEY_W-1:0] w;
        int row;
        row = key / kpsd_pkg::COLS;
        w = '0;
        for (int r = 0; r < kpsd_pkg::ROWS; r++) begin
            if (r < row)
                w[r*kpsd_pkg::COLS +: kpsd_pkg::COLS] = dead_row();
            else if (r == row)
                w[r*kpsd_pkg::COLS +: kpsd_pkg::COLS] = 4'(1 << (key % kpsd_pkg::COLS));
            else
                w[r*kpsd_pkg::COLS +: kpsd_pkg::COLS] = 4'($urandom_range(0, 15));
        end
        return w;
    endfunction

    function automatic logic [kpsd_pkg::KEY_W-1:0] release_word();
        return {dead_row(), dead_row(), dead_row(), dead_row()};
    endfunction

    // advance the display model by one accepted tick
    task automatic predict_tick(input logic [kpsd_pkg::KEY_W-1:0] keys);
        logic [7:0]                   code;
        logic [kpsd_pkg::SUM_W-1:0]   sum;
        glyph_t                       g;
        code = key_glyph(keys);
        if (code != NO_KEY && code != last_code) begin
            ring_glyph[write_ptr] = code[kpsd_pkg::SEG_W-1:0];
            write_ptr = next_pos(write_ptr);
            new_keys++;
        end
        last_code = code;
        sum = {1'b0, scan_ptr} + {1'b0, write_ptr};
        if (sum >= kpsd_pkg::SUM_W'(kpsd_pkg::DIGITS))
            sum = sum - kpsd_pkg::SUM_W'(kpsd_pkg::DIGITS);
        g.segments     = ring_glyph[sum[kpsd_pkg::POS_W-1:0]];
        g.digit_select = kpsd_pkg::DIGIT_SEL_W'(scan_ptr);
        expected_glyphs.push_back(g);
        scan_ptr = next_pos(scan_ptr);
        ticks_sent++;
    endtask

    // cycle counter, idle-rate phases, timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0) begin
            case ($urandom_range(0, 3))
                0, 1:    src_rate <= 0;
                2:       src_rate <= 15;
                default: src_rate <= 40;
            endcase
            case ($urandom_range(0, 3))
                0, 1:    snk_rate <= 0;
                2:       snk_rate <= 15;
                default: snk_rate <= 40;
            endcase
        end
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d glyphs outstanding",
                     cycle_count, expected_glyphs.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // source driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end else if (pending_keys.size() > QUIET_TAIL &&
                         $urandom_range(0, 99) < src_rate) begin
                s_tvalid <= 1'b0;
                src_gap  <= $urandom_range(0, 6);
            end else if (pending_keys.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_keys.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // predict on every accepted tick
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            predict_tick(s_tdata);
    end

    // sink backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            snk_stall <= 0;
        end else if (snk_stall > 0) begin
            m_tready  <= 1'b0;
            snk_stall <= snk_stall - 1;
        end else if (pending_keys.size() > QUIET_TAIL &&
                     $urandom_range(0, 99) < snk_rate) begin
            m_tready  <= 1'b0;
            snk_stall <= $urandom_range(0, 6);
        end else begin
            m_tready  <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        glyph_t want;
        logic [kpsd_pkg::SEG_W-1:0]       got_seg;
        logic [kpsd_pkg::DIGIT_SEL_W-1:0] got_sel;
        if (aresetn && m_tvalid && m_tready) begin
            got_seg = m_tdata[SEG_LO +: kpsd_pkg::SEG_W];
            got_sel = m_tdata[SEL_LO +: kpsd_pkg::DIGIT_SEL_W];
            glyphs_seen++;
            if (expected_glyphs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected transfer seg=%h sel=%0d",
                             $realtime, got_seg, got_sel);
            end else begin
                want = expected_glyphs.pop_front();
                if (got_seg !== want.segments || got_sel !== want.digit_select) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: glyph %0d seg exp %h got %h, sel exp %0d got %0d",
                                 $realtime, glyphs_seen, want.segments, got_seg,
                                 want.digit_select, got_sel);
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int produced;
        int pick;
        int key;
        int hold;

        for (int i = 0; i < kpsd_pkg::DIGITS; i++)
            ring_glyph[i] = '0;
        write_ptr = '0;
        scan_ptr  = '0;
        last_code = NO_KEY;

        // directed: extremes, every key, skipped rows, hold, re-press
        pending_keys.push_back(16'h0000);
        pending_keys.push_back(16'hffff);
        for (int k = 0; k < kpsd_pkg::KEY_W; k++)
            pending_keys.push_back(16'(1 << k));
        pending_keys.push_back(16'h0023);   // row 0 has two keys, row 1 col 1 wins
        pending_keys.push_back(16'h8fff);   // only row 3 qualifies
        pending_keys.push_back(16'h0001);   // held key
        pending_keys.push_back(16'h0001);
        pending_keys.push_back(16'hf001);   // same code, clutter in later rows
        pending_keys.push_back(16'h0000);   // release
        pending_keys.push_back(16'h0001);   // same key pressed again

        // random: mostly held presses with clutter, some releases and noise
        produced = 0;
        while (produced < N_RANDOM) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                key  = $urandom_range(0, kpsd_pkg::KEY_W - 1);
                hold = $urandom_range(1, 6);
                for (int h = 0; h < hold; h++)
                    pending_keys.push_back(press_word(key));
                produced += hold;
                if ($urandom_range(0, 1)) begin
                    pending_keys.push_back(release_word());
                    produced++;
                end
            end else if (pick < 85) begin
                hold = $urandom_range(1, 3);
                for (int h = 0; h < hold; h++)
                    pending_keys.push_back(release_word());
                produced += hold;
            end else begin
                pending_keys.push_back(16'($urandom_range(0, 65535)));
                produced++;
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // all ticks accepted, then all glyphs back, then a short drain
        while (pending_keys.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_glyphs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d ticks driven, %0d new keys entered the ring, %0d glyphs checked",
                 ticks_sent, new_keys, glyphs_seen);
        $display("%0d mismatches, %0d glyphs left over", mismatches, expected_glyphs.size());
        if (mismatches == 0 && expected_glyphs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ keypad_to_scrolling_seven_segment_top.f @@
rtl/kpsd_pkg.sv
rtl/kpsd_key_decode.sv
rtl/keypad_to_scrolling_seven_segment_top.sv
tb/tb.sv
